// ===== rtl/core/hss_pkg.sv =====
// hss_pkg: widths, register indexes and shared types of the heat stencil step
// no dependencies; used by the interfaces, the top level and the update pipeline
package hss_pkg;

    // field widths
    localparam int VALUE_W    = 32;
    localparam int COEF_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // datapath widths: laplacian terms, weighted products, rounded sum
    localparam int LAP_W   = VALUE_W + 2;
    localparam int PROD_W  = LAP_W + COEF_W + 1;
    localparam int SUM_W   = PROD_W + 1;
    localparam int FRAC_W  = 16;
    localparam int SHIFT_W = SUM_W - FRAC_W;
    localparam int RES_W   = SHIFT_W + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_V = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_H = 2'd1;

    localparam logic [COEF_W-1:0] COEF_RESET = 16'd16384;

    // round to nearest, ties up, when dropping the low fraction bits
    localparam logic signed [SUM_W-1:0] ROUND_HALF = 52'sd32768;

    // result tag carried along the update pipeline
    typedef struct packed {
        logic emit;
        logic last;
    } t_tag;

endpackage

// ===== rtl/core/hss_if.sv =====
// hss_if: valid/ready channel interfaces of the heat stencil step
// depends on hss_pkg for field widths
interface hss_cell_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [hss_pkg::VALUE_W-1:0]      cell_value;
    logic                                    grid_start;

    modport source (output valid, output cell_value, output grid_start, input ready);
    modport sink   (input valid, input cell_value, input grid_start, output ready);
endinterface

interface hss_result_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [hss_pkg::VALUE_W-1:0]      new_value;
    logic                                    tile_last;

    modport source (output valid, output new_value, output tile_last, input ready);
    modport sink   (input valid, input new_value, input tile_last, output ready);
endinterface

interface hss_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [hss_pkg::CFG_IDX_W-1:0]           index;
    logic [hss_pkg::CFG_DATA_W-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/hss_ram.sv =====
// hss_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module hss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 66
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, read returns old data on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/hss_update.sv =====
// hss_update: weighted laplacian, rounding and saturation, three register stages
// depends on hss_pkg; the last stage is the output register of the block
module hss_update (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  logic [hss_pkg::COEF_W-1:0]            i_coef_v,
    input  logic [hss_pkg::COEF_W-1:0]            i_coef_h,
    input  logic signed [hss_pkg::LAP_W-1:0]      i_lap_v,
    input  logic signed [hss_pkg::LAP_W-1:0]      i_lap_h,
    input  logic signed [hss_pkg::VALUE_W-1:0]    i_u,
    input  hss_pkg::t_tag                         i_tag,
    output logic                                  o_valid,
    output logic signed [hss_pkg::VALUE_W-1:0]    o_value,
    output logic                                  o_last
);

    localparam int VW = hss_pkg::VALUE_W;
    localparam int PW = hss_pkg::PROD_W;
    localparam int SW = hss_pkg::SUM_W;
    localparam int HW = hss_pkg::SHIFT_W;
    localparam int RW = hss_pkg::RES_W;

    // stage c: products
    hss_pkg::t_tag         r_c_tag;
    logic signed [PW-1:0]  r_c_pv, r_c_ph;
    logic signed [VW-1:0]  r_c_u;
    // stage d: rounded sum
    hss_pkg::t_tag         r_d_tag;
    logic signed [HW-1:0]  r_d_sum;
    logic signed [VW-1:0]  r_d_u;
    // stage e: output register
    logic                  r_e_valid;
    logic                  r_e_last;
    logic signed [VW-1:0]  r_e_value;

    logic signed [PW-1:0]  n_pv, n_ph;
    logic signed [SW-1:0]  n_sum;
    logic signed [RW-1:0]  n_res;
    logic signed [VW-1:0]  n_value;

    // coefficient times laplacian, coefficients are unsigned
    always_comb begin
        n_pv = $signed({1'b0, i_coef_v}) * i_lap_v;
        n_ph = $signed({1'b0, i_coef_h}) * i_lap_h;
    end

    // sum of both terms plus half an lsb
    always_comb begin
        n_sum = {r_c_pv[PW-1], r_c_pv} + {r_c_ph[PW-1], r_c_ph} + hss_pkg::ROUND_HALF;
    end

    // add centre value and saturate to 32 bits
    always_comb begin
        n_res = {{(RW-VW){r_d_u[VW-1]}}, r_d_u} + {r_d_sum[HW-1], r_d_sum};
        if (n_res[RW-1:VW-1] == {(RW-VW+1){n_res[RW-1]}}) begin
            n_value = n_res[VW-1:0];
        end else if (n_res[RW-1]) begin
            n_value = {1'b1, {(VW-1){1'b0}}};
        end else begin
            n_value = {1'b0, {(VW-1){1'b1}}};
        end
    end

    // pipeline registers, all move on the common advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_tag   <= '0;
            r_d_tag   <= '0;
            r_e_valid <= 1'b0;
        end else if (i_adv) begin
            r_c_tag   <= i_tag;
            r_d_tag   <= r_c_tag;
            r_e_valid <= r_d_tag.emit;
        end
        if (i_adv) begin
            r_c_pv    <= n_pv;
            r_c_ph    <= n_ph;
            r_c_u     <= i_u;
            r_d_sum   <= n_sum[SW-1:hss_pkg::FRAC_W];
            r_d_u     <= r_c_u;
            r_e_value <= n_value;
            r_e_last  <= r_d_tag.last;
        end
    end

    assign o_valid = r_e_valid;
    assign o_value = r_e_value;
    assign o_last  = r_e_last;

endmodule

// ===== rtl/core/heat_stencil_step.sv =====
// heat_stencil_step: one explicit time step of 2d heat diffusion, five-point stencil
// depends on hss_pkg, hss_if, hss_ram and hss_update
//
//   channel    dir  transaction                       handshake
//   i_cell     in   cell_value, grid_start            valid/ready
//   o_result   out  new_value, tile_last              valid/ready
//   i_cfg      in   index, data (coefficient write)   valid/ready, ready always high
//
// one cell per cycle while results are taken; each passes stage b, the window and stages c-e.
// the rate is set by the line ram: one read and one write of a row pair per cell.
// reset clears counters, window, pipeline valid bits; coefficients preset, ram not cleared.
// a result that is not taken stalls the whole pipeline, input ready drops with it.
module heat_stencil_step #(
    parameter int TILE = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hss_cell_if.sink      i_cell,
    hss_result_if.source  o_result,
    hss_cfg_if.sink       i_cfg
);

    localparam int SPAN = TILE + 2;
    localparam int AW   = $clog2(SPAN);
    localparam int VW   = hss_pkg::VALUE_W;
    localparam int LW   = hss_pkg::LAP_W;

    logic                  adv;
    logic                  in_acc;
    logic                  upd_valid;

    logic [hss_pkg::COEF_W-1:0] r_coef_v, r_coef_h;

    logic [AW-1:0]         r_col, r_row;
    logic [AW-1:0]         cur_col, cur_row, n_col, n_row;

    // stage b: item whose line pair is being read
    logic                  r_b_valid;
    hss_pkg::t_tag         r_b_tag;
    logic [AW-1:0]         r_b_col;
    logic signed [VW-1:0]  r_b_cell;
    logic                  r_fwd;
    logic [2*VW-1:0]       r_fwd_data;

    // window: column c-1 top, middle, bottom and column c-2 middle
    logic signed [VW-1:0]  r_w_top, r_w_mid, r_w_bot, r_w_left;

    logic                  ram_we;
    logic [2*VW-1:0]       ram_wdata, ram_rdata, pair;
    logic signed [VW-1:0]  above, middle;

    logic signed [LW-1:0]  r_lap_v, r_lap_h, n_lap_v, n_lap_h;
    logic signed [VW-1:0]  r_u;
    hss_pkg::t_tag         r_tag, n_tag;

    // pipeline advance, input ready follows it
    assign adv          = !upd_valid || o_result.ready;
    assign i_cell.ready = adv;
    assign in_acc       = i_cell.valid && adv;

    // coefficient writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_v <= hss_pkg::COEF_RESET;
            r_coef_h <= hss_pkg::COEF_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                hss_pkg::CFG_COEF_V: r_coef_v <= i_cfg.data;
                hss_pkg::CFG_COEF_H: r_coef_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // position of the incoming cell and the next position
    always_comb begin
        cur_col = i_cell.grid_start ? '0 : r_col;
        cur_row = i_cell.grid_start ? '0 : r_row;
        if (cur_col == AW'(SPAN - 1)) begin
            n_col = '0;
            n_row = (cur_row == AW'(SPAN - 1)) ? '0 : cur_row + 1'b1;
        end else begin
            n_col = cur_col + 1'b1;
            n_row = cur_row;
        end
        n_tag.emit = (cur_row >= AW'(2)) && (cur_col >= AW'(2));
        n_tag.last = (cur_row == AW'(SPAN - 1)) && (cur_col == AW'(SPAN - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // line ram holds {line_above, line_middle} per column
    assign ram_we    = adv && r_b_valid;
    assign ram_wdata = {middle, r_b_cell};

    hss_ram #(
        .WIDTH (2 * VW),
        .DEPTH (SPAN)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_b_col),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (cur_col),
        .o_rdata (ram_rdata)
    );

    // stage b registers and forwarding of a write to the column being read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else if (adv) begin
            r_b_valid <= in_acc;
            if (in_acc) begin
                r_fwd <= ram_we && (r_b_col == cur_col);
            end
        end
        if (in_acc) begin
            r_b_tag    <= n_tag;
            r_b_col    <= cur_col;
            r_b_cell   <= i_cell.cell_value;
            r_fwd_data <= ram_wdata;
        end
    end

    assign pair   = r_fwd ? r_fwd_data : ram_rdata;
    assign above  = pair[2*VW-1:VW];
    assign middle = pair[VW-1:0];

    // laplacian terms around the centre of the window
    always_comb begin
        n_lap_v = LW'(r_w_top) + LW'(r_w_bot) - (LW'(r_w_mid) <<< 1);
        n_lap_h = LW'(r_w_left) + LW'(middle) - (LW'(r_w_mid) <<< 1);
    end

    // window shift and laplacian registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_top  <= '0;
            r_w_mid  <= '0;
            r_w_bot  <= '0;
            r_w_left <= '0;
            r_tag    <= '0;
        end else if (adv) begin
            r_tag <= r_b_valid ? r_b_tag : '0;
            if (r_b_valid) begin
                r_w_top  <= above;
                r_w_mid  <= middle;
                r_w_bot  <= r_b_cell;
                r_w_left <= r_w_mid;
            end
        end
        if (adv) begin
            r_lap_v <= n_lap_v;
            r_lap_h <= n_lap_h;
            r_u     <= r_w_mid;
        end
    end

    hss_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_coef_v (r_coef_v),
        .i_coef_h (r_coef_h),
        .i_lap_v  (r_lap_v),
        .i_lap_h  (r_lap_h),
        .i_u      (r_u),
        .i_tag    (r_tag),
        .o_valid  (upd_valid),
        .o_value  (o_result.new_value),
        .o_last   (o_result.tile_last)
    );

    assign o_result.valid = upd_valid;

endmodule

// ===== rtl/core/hss_checker.sv =====
// hss_checker: port-level assertions of the heat stencil step and its bind
// depends on heat_stencil_step ports only
module hss_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_cfg_ready
);

    // a result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before its transaction");

    // input stalls only behind a result that is not taken
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a blocked result");

    // a new result appears only after the pipeline moved
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_ready))
        else $error("result appeared while the pipeline was stalled");

    // reset empties the output and keeps config open
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_cfg_ready)
        else $error("output not empty after reset");

endmodule

bind heat_stencil_step hss_checker u_hss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cell.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_cfg_ready (i_cfg.ready)
);
